[hw/rtl/mipd_pkg.sv]
// Shared types, constants and register codes of the IR presence detector.
`default_nettype none
package mipd_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned DelayW   = 16;
  localparam int unsigned TxCntW   = 17;
  localparam int unsigned RxCntW   = 18;
  localparam int unsigned RxLimW   = 17;

  localparam int unsigned WindowSizeDef = 8;

  localparam logic [DelayW-1:0] TxDelayRst    = 16'd100;
  localparam logic [DelayW-1:0] RespDelayRst  = 16'd0;
  localparam logic              TxStartRst    = 1'b0;
  localparam logic              BeamBreakRst  = 1'b0;
  localparam logic              RxActHighRst  = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TX_DELAY       = 3'd0,
    CFG_RESPONSE_DELAY = 3'd1,
    CFG_TX_START_LEVEL = 3'd2,
    CFG_BEAM_BREAK     = 3'd3,
    CFG_RX_ACTIVE_HIGH = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [DelayW-1:0] tx_delay;
    logic [DelayW-1:0] response_delay;
    logic              tx_start_level;
    logic              beam_break_mode;
    logic              rx_active_high;
    logic              load_tx_level;
  } cfg_t;

  typedef struct packed {
    logic tx_drive;
    logic rx_sampled;
    logic activated;
    logic activate_event;
    logic deactivate_event;
  } res_t;

endpackage
`default_nettype wire

[hw/rtl/mipd_if.sv]
// Valid/ready channel interfaces for tick words and result words.
`default_nettype none
interface mipd_in_if;
  logic valid;
  logic ready;
  logic rx_level;

  modport source (output valid, output rx_level, input ready);
  modport sink (input valid, input rx_level, output ready);
endinterface

interface mipd_out_if;
  logic valid;
  logic ready;
  logic tx_drive;
  logic rx_sampled;
  logic activated;
  logic activate_event;
  logic deactivate_event;

  modport source (output valid, output tx_drive, output rx_sampled, output activated,
                  output activate_event, output deactivate_event, input ready);
  modport sink (input valid, input tx_drive, input rx_sampled, input activated,
                input activate_event, input deactivate_event, output ready);
endinterface
`default_nettype wire

[hw/rtl/mipd_cfg.sv]
// Configuration register file of the IR presence detector.
`default_nettype none
module mipd_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [mipd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [mipd_pkg::CfgDataW-1:0] cfg_data_i,
  output mipd_pkg::cfg_t                     cfg_o
);

  logic [mipd_pkg::DelayW-1:0] tx_delay_q;
  logic [mipd_pkg::DelayW-1:0] resp_delay_q;
  logic                        tx_start_q;
  logic                        beam_break_q;
  logic                        rx_act_high_q;
  logic                        load_tx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_delay_q    <= mipd_pkg::TxDelayRst;
      resp_delay_q  <= mipd_pkg::RespDelayRst;
      tx_start_q    <= mipd_pkg::TxStartRst;
      beam_break_q  <= mipd_pkg::BeamBreakRst;
      rx_act_high_q <= mipd_pkg::RxActHighRst;
    end else if (cfg_we_i) begin
      unique case (mipd_pkg::cfg_idx_e'(cfg_idx_i))
        mipd_pkg::CFG_TX_DELAY:       tx_delay_q    <= cfg_data_i[mipd_pkg::DelayW-1:0];
        mipd_pkg::CFG_RESPONSE_DELAY: resp_delay_q  <= cfg_data_i[mipd_pkg::DelayW-1:0];
        mipd_pkg::CFG_TX_START_LEVEL: tx_start_q    <= cfg_data_i[0];
        mipd_pkg::CFG_BEAM_BREAK:     beam_break_q  <= cfg_data_i[0];
        mipd_pkg::CFG_RX_ACTIVE_HIGH: rx_act_high_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // A start-level write also presets the running transmitter level.
  assign load_tx = cfg_we_i &&
                   (mipd_pkg::cfg_idx_e'(cfg_idx_i) == mipd_pkg::CFG_TX_START_LEVEL);

  always_comb begin
    cfg_o.tx_delay        = tx_delay_q;
    cfg_o.response_delay  = resp_delay_q;
    cfg_o.tx_start_level  = load_tx ? cfg_data_i[0] : tx_start_q;
    cfg_o.beam_break_mode = beam_break_q;
    cfg_o.rx_active_high  = rx_act_high_q;
    cfg_o.load_tx_level   = load_tx;
  end

endmodule
`default_nettype wire

[hw/rtl/mipd_core.sv]
// Tick datapath: toggle and sample timers, judgment, window and edge detect.
`default_nettype none
module mipd_core #(
  parameter int unsigned WindowSize = mipd_pkg::WindowSizeDef
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire mipd_pkg::cfg_t cfg_i,
  input  wire logic           step_i,
  input  wire logic           rx_level_i,
  output mipd_pkg::res_t      res_o
);

  localparam int unsigned PosW = (WindowSize > 1) ? $clog2(WindowSize) : 1;
  localparam logic [PosW-1:0] PosLast = PosW'(WindowSize - 1);

  logic [mipd_pkg::TxCntW-1:0] tx_cnt_q, tx_cnt_d, tx_inc;
  logic [mipd_pkg::RxCntW-1:0] rx_cnt_q, rx_cnt_d, rx_inc;
  logic [mipd_pkg::RxLimW-1:0] rx_limit;
  logic                        tx_level_q, tx_level_d;
  logic                        rx_raw_q, rx_raw_d;
  logic [WindowSize-1:0]       win_q, win_d;
  logic [PosW-1:0]             pos_q, pos_d;
  logic                        active_q, active_d;
  logic                        tx_fire, rx_fire, corr, judge;

  always_comb begin
    tx_inc   = tx_cnt_q + 1'b1;
    rx_inc   = rx_cnt_q + 1'b1;
    rx_limit = {1'b0, cfg_i.tx_delay} + {1'b0, cfg_i.response_delay};
    tx_fire  = tx_inc > {1'b0, cfg_i.tx_delay};
    rx_fire  = rx_inc > {1'b0, rx_limit};

    tx_cnt_d   = tx_fire ? '0 : tx_inc;
    rx_cnt_d   = rx_fire ? '0 : rx_inc;
    tx_level_d = tx_level_q ^ tx_fire;
    rx_raw_d   = rx_fire ? rx_level_i : rx_raw_q;

    // Judge against the already updated transmitter level.
    corr = cfg_i.rx_active_high ? rx_level_i : ~rx_level_i;
    if (cfg_i.beam_break_mode) begin
      judge = ~tx_level_d | ~corr;
    end else begin
      judge = (corr == tx_level_d);
    end

    win_d = win_q;
    pos_d = pos_q;
    if (rx_fire) begin
      for (int i = 0; i < WindowSize; i++) begin
        if (pos_q == PosW'(i)) win_d[i] = judge;
      end
      pos_d = (pos_q == PosLast) ? '0 : pos_q + 1'b1;
    end

    active_d = &win_d;

    res_o.tx_drive         = tx_level_d;
    res_o.rx_sampled       = rx_raw_d;
    res_o.activated        = active_d;
    res_o.activate_event   = active_d & ~active_q;
    res_o.deactivate_event = ~active_d & active_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_cnt_q   <= '0;
      rx_cnt_q   <= '0;
      tx_level_q <= mipd_pkg::TxStartRst;
      rx_raw_q   <= 1'b0;
      win_q      <= '0;
      pos_q      <= '0;
      active_q   <= 1'b0;
    end else if (cfg_i.load_tx_level) begin
      tx_level_q <= cfg_i.tx_start_level;
    end else if (step_i) begin
      tx_cnt_q   <= tx_cnt_d;
      rx_cnt_q   <= rx_cnt_d;
      tx_level_q <= tx_level_d;
      rx_raw_q   <= rx_raw_d;
      win_q      <= win_d;
      pos_q      <= pos_d;
      active_q   <= active_d;
    end
  end

  // A window slot is written only on a receiver sample.
  a_win_only_on_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!step_i) && !$past(cfg_i.load_tx_level) |-> $stable(win_q) && $stable(pos_q))
    else $error("window changed without a tick");

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosLast)
    else $error("window position out of range");

  a_active_matches_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q == (&win_q))
    else $error("active flag disagrees with window");

endmodule
`default_nettype wire

[hw/rtl/modulated_ir_presence_detector_unit.sv]
// Top level of the modulated IR presence detector.
//
//  channel | dir | word                                         | handshake
//  in_s    | in  | rx_level                                     | valid/ready
//  out_s   | out | tx_drive rx_sampled activated act/deact evts | valid/ready
//  cfg     | in  | cfg_we_i cfg_idx_i cfg_data_i                | write enable only
//
// One tick word per clock unless out_s stalls; result in the next cycle.
// The timers, judgment and window AND fit between the state registers and
// the single result register.
// Reset clears timers, window and flags and restores register defaults.
// When the result register is full and not taken, input ready drops.
`default_nettype none
module modulated_ir_presence_detector_unit #(
  parameter int unsigned WindowSize = mipd_pkg::WindowSizeDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  mipd_in_if.sink                            in_s,
  mipd_out_if.source                         out_s,
  input  wire logic                          cfg_we_i,
  input  wire logic [mipd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [mipd_pkg::CfgDataW-1:0] cfg_data_i
);

  mipd_pkg::cfg_t cfg;
  mipd_pkg::res_t res, res_q;
  logic           out_valid_q;
  logic           accept;

  mipd_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  mipd_core #(
    .WindowSize (WindowSize)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .step_i     (accept),
    .rx_level_i (in_s.rx_level),
    .res_o      (res)
  );

  assign in_s.ready = ~out_valid_q | out_s.ready;
  assign accept     = in_s.valid & in_s.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_s.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Payload needs no reset; load on every accepted word.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign out_s.valid            = out_valid_q;
  assign out_s.tx_drive         = res_q.tx_drive;
  assign out_s.rx_sampled       = res_q.rx_sampled;
  assign out_s.activated        = res_q.activated;
  assign out_s.activate_event   = res_q.activate_event;
  assign out_s.deactivate_event = res_q.deactivate_event;

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted word produced no result");

  a_rise_is_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.activate_event |-> res_q.activated)
    else $error("activate event without activated state");

  a_fall_is_inactive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.deactivate_event |-> !res_q.activated)
    else $error("deactivate event with activated state");

endmodule
`default_nettype wire

[tb/modulated_ir_presence_detector_check.sv]
// Checker: predicts every result word of the IR presence detector and compares.
`timescale 1ns / 1ps
module modulated_ir_presence_detector_check
  import mipd_pkg::*;
#(
  parameter int unsigned WindowSize = WindowSizeDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  mipd_in_if                  in_m,
  mipd_out_if                 out_m,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  fail_cnt_o,
  output int                  pending_o,
  output int                  checked_o,
  output int                  rise_cnt_o,
  output int                  fall_cnt_o
);

  localparam int unsigned PosW = (WindowSize > 1) ? $clog2(WindowSize) : 1;

  // register mirror
  logic [DelayW-1:0] tx_delay_q;
  logic [DelayW-1:0] resp_delay_q;
  logic              start_lvl_q;
  logic              beam_mode_q;
  logic              rx_high_q;

  // detector state mirror
  logic [TxCntW-1:0]     tx_cnt;
  logic [RxCntW-1:0]     rx_cnt;
  logic                  tx_lvl;
  logic                  rx_raw;
  logic [WindowSize-1:0] judge_win;
  logic [PosW-1:0]       win_pos;
  logic                  on_q;

  res_t expected_res_q[$];
  res_t want;
  int   pushed;
  int   popped;
  int   mismatches;
  int   rises;
  int   falls;

  assign fail_cnt_o = mismatches;
  assign pending_o  = pushed - popped;
  assign checked_o  = popped;
  assign rise_cnt_o = rises;
  assign fall_cnt_o = falls;

  function automatic void apply_write(input logic [CfgIdxW-1:0] idx,
                                      input logic [CfgDataW-1:0] data);
    case (cfg_idx_e'(idx))
      CFG_TX_DELAY:       tx_delay_q = data[DelayW-1:0];
      CFG_RESPONSE_DELAY: resp_delay_q = data[DelayW-1:0];
      CFG_TX_START_LEVEL: begin
        // preset: the start level takes effect at once
        start_lvl_q = data[0];
        tx_lvl      = data[0];
      end
      CFG_BEAM_BREAK:     beam_mode_q = data[0];
      CFG_RX_ACTIVE_HIGH: rx_high_q = data[0];
      default: ;
    endcase
  endfunction

  function automatic res_t detector_tick(input logic rx_in);
    res_t             r;
    logic [RxLimW-1:0] limit;
    logic             corr;
    logic             judge;
    logic             now_on;
    limit  = RxLimW'(tx_delay_q) + RxLimW'(resp_delay_q);
    tx_cnt = tx_cnt + 1'b1;
    rx_cnt = rx_cnt + 1'b1;
    if (tx_cnt > TxCntW'(tx_delay_q)) begin
      tx_cnt = '0;
      tx_lvl = ~tx_lvl;
    end
    if (rx_cnt > RxCntW'(limit)) begin
      rx_cnt = '0;
      rx_raw = rx_in;
      corr   = rx_high_q ? rx_raw : ~rx_raw;
      // judge against the transmitter level of this very tick
      if (beam_mode_q) judge = !tx_lvl || !corr;
      else judge = (corr == tx_lvl);
      judge_win[win_pos] = judge;
      win_pos = (win_pos == PosW'(WindowSize - 1)) ? '0 : win_pos + 1'b1;
    end
    now_on             = &judge_win;
    r.activate_event   = now_on && !on_q;
    r.deactivate_event = !now_on && on_q;
    on_q               = now_on;
    r.tx_drive         = tx_lvl;
    r.rx_sampled       = rx_raw;
    r.activated        = on_q;
    return r;
  endfunction

  function automatic void check_bit(input string field, input logic exp_v, input logic got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %b, actual %b", field, exp_v, got_v);
      mismatches++;
    end
  endfunction

  initial begin
    mismatches = 0;
    rises      = 0;
    falls      = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_delay_q   = TxDelayRst;
      resp_delay_q = RespDelayRst;
      start_lvl_q  = TxStartRst;
      beam_mode_q  = BeamBreakRst;
      rx_high_q    = RxActHighRst;
      tx_cnt       = '0;
      rx_cnt       = '0;
      tx_lvl       = start_lvl_q;
      rx_raw       = 1'b0;
      judge_win    = '0;
      win_pos      = '0;
      on_q         = 1'b0;
      expected_res_q.delete();
      pushed <= 0;
      popped <= 0;
    end else begin
      if (out_m.valid && out_m.ready) begin
        if (out_m.activate_event === 1'b1) rises++;
        if (out_m.deactivate_event === 1'b1) falls++;
        if (expected_res_q.size() == 0) begin
          $error("result word with no tick word pending");
          mismatches++;
        end else begin
          want = expected_res_q.pop_front();
          check_bit("tx_drive", want.tx_drive, out_m.tx_drive);
          check_bit("rx_sampled", want.rx_sampled, out_m.rx_sampled);
          check_bit("activated", want.activated, out_m.activated);
          check_bit("activate_event", want.activate_event, out_m.activate_event);
          check_bit("deactivate_event", want.deactivate_event, out_m.deactivate_event);
          popped <= popped + 1;
        end
      end
      if (cfg_we_i) apply_write(cfg_idx_i, cfg_data_i);
      if (in_m.valid && in_m.ready) begin
        expected_res_q.push_back(detector_tick(in_m.rx_level));
        pushed <= pushed + 1;
      end
    end
  end

endmodule

[tb/modulated_ir_presence_detector_unit_test.sv]
// Testbench top: clock, reset, tick stimulus, register phases and verdict.
`timescale 1ns / 1ps
module modulated_ir_presence_detector_unit_test;
  import mipd_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgIdxSpare  = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 3'd7;
  localparam int unsigned        NumPhases    = 12;
  localparam int unsigned        PhaseTicks   = 110;

  logic                clk_i  = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  int fail_cnt;
  int pending;
  int checked;
  int rise_cnt;
  int fall_cnt;

  // stimulus shaping: follow the transmitter phase so echoes can be aimed
  int unsigned echo_cnt;
  int unsigned echo_delay;
  bit          echo_lvl;
  bit          echo_beam;
  bit          echo_high;
  bit          present;
  bit          calm;
  int          words_sent;
  int          setups;
  int          hold_left;
  bit          hold_done;

  mipd_in_if  tick_if ();
  mipd_out_if res_if ();

  modulated_ir_presence_detector_unit u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_s      (tick_if),
    .out_s     (res_if),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  modulated_ir_presence_detector_check u_check (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_m      (tick_if),
    .out_m     (res_if),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .fail_cnt_o(fail_cnt),
    .pending_o (pending),
    .checked_o (checked),
    .rise_cnt_o(rise_cnt),
    .fall_cnt_o(fall_cnt)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // result side: random stalls, one long hold-off, calm stretches
  initial begin
    res_if.ready <= 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else if (!hold_done && words_sent >= 400) begin
        hold_done = 1'b1;
        hold_left = 300;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= calm || ($urandom_range(99) >= 32);
      end
    end
  end

  // receiver level that makes the next judgment true (hit) or false
  function automatic bit echo_rx(input bit hit);
    bit next_lvl;
    next_lvl = echo_lvl ^ ((echo_cnt + 1) > echo_delay);
    if (echo_beam) begin
      if (!next_lvl) return bit'($urandom_range(1));
      return hit ? ~echo_high : echo_high;
    end
    return hit ? (next_lvl ^ ~echo_high) : (next_lvl ^ echo_high);
  endfunction

  task automatic put_tick(input bit rx);
    while (!calm && $urandom_range(99) < 32) begin
      tick_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    tick_if.valid    <= 1'b1;
    tick_if.rx_level <= rx;
    do @(posedge clk_i); while (!tick_if.ready);
    words_sent++;
    echo_cnt++;
    if (echo_cnt > echo_delay) begin
      echo_cnt = 0;
      echo_lvl = ~echo_lvl;
    end
  endtask

  // drop valid and wait until every result word is back
  task automatic quiesce();
    tick_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (cfg_idx_e'(idx))
      CFG_TX_DELAY:       echo_delay = 32'(data);
      CFG_TX_START_LEVEL: echo_lvl = data[0];
      CFG_BEAM_BREAK:     echo_beam = data[0];
      CFG_RX_ACTIVE_HIGH: echo_high = data[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic end_writes();
    cfg_we <= 1'b0;
    @(posedge clk_i);
    setups++;
  endtask

  task automatic run_ticks(input int n);
    for (int i = 0; i < n; i++) begin
      if (present) begin
        if ($urandom_range(59) == 0) present = 1'b0;
      end else if ($urandom_range(19) == 0) begin
        present = 1'b1;
      end
      put_tick(echo_rx(present ? ($urandom_range(99) < 96) : bit'($urandom_range(1))));
    end
  endtask

  task automatic random_setup();
    logic [DelayW-1:0] tx_d;
    logic [DelayW-1:0] resp_d;
    tx_d   = DelayW'(($urandom_range(3) != 0) ? $urandom_range(3) : $urandom_range(4, 30));
    resp_d = DelayW'(($urandom_range(3) != 0) ? $urandom_range(2) : $urandom_range(3, 20));
    quiesce();
    write_reg(CFG_TX_DELAY, tx_d);
    write_reg(CFG_RESPONSE_DELAY, resp_d);
    write_reg(CFG_BEAM_BREAK, CfgDataW'($urandom_range(65535)));
    write_reg(CFG_RX_ACTIVE_HIGH, CfgDataW'($urandom_range(65535)));
    if ($urandom_range(1)) write_reg(CFG_TX_START_LEVEL, CfgDataW'($urandom_range(65535)));
    if ($urandom_range(3) == 0) write_reg(CfgIdxSpare, CfgDataW'($urandom_range(65535)));
    end_writes();
  endtask

  initial begin
    tick_if.valid    <= 1'b0;
    tick_if.rx_level <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_idx          <= '0;
    cfg_data         <= '0;
    echo_cnt   = 0;
    echo_delay = 32'(TxDelayRst);
    echo_lvl   = TxStartRst;
    echo_beam  = BeamBreakRst;
    echo_high  = RxActHighRst;
    present    = 1'b1;
    calm       = 1'b0;
    words_sent = 0;
    setups     = 1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // register defaults out of reset
    put_tick(1'b0);
    put_tick(1'b1);

    // writes to missing registers are ignored; fast reflection mode
    quiesce();
    write_reg(CfgIdxUnused, 16'hFFFF);
    write_reg(CfgIdxSpare, 16'hFFFF);
    write_reg(CFG_TX_DELAY, 16'h0000);
    write_reg(CFG_RESPONSE_DELAY, 16'h0000);
    end_writes();
    repeat (10) put_tick(echo_rx(1'b1));
    repeat (2) put_tick(echo_rx(1'b0));

    // beam-break, inverted receiver, start level preset; upper data bits dropped
    quiesce();
    write_reg(CFG_BEAM_BREAK, 16'hFFFF);
    write_reg(CFG_RX_ACTIVE_HIGH, 16'hFFFE);
    write_reg(CFG_TX_START_LEVEL, 16'h0003);
    end_writes();
    repeat (10) put_tick(echo_rx(1'b1));
    put_tick(echo_rx(1'b0));

    for (int p = 0; p < NumPhases; p++) begin
      calm = (p == 5) || (p == 6);
      if (p == 0) begin
        // widest delays, then lower them while the timers are mid-count
        quiesce();
        write_reg(CFG_TX_DELAY, 16'hFFFF);
        write_reg(CFG_RESPONSE_DELAY, 16'hFFFF);
        write_reg(CFG_BEAM_BREAK, 16'h0000);
        write_reg(CFG_RX_ACTIVE_HIGH, 16'h0001);
        end_writes();
        run_ticks(40);
        quiesce();
        write_reg(CFG_TX_DELAY, 16'h0002);
        write_reg(CFG_RESPONSE_DELAY, 16'h0001);
        end_writes();
        run_ticks(PhaseTicks - 40);
      end else begin
        random_setup();
        run_ticks(PhaseTicks);
      end
    end
    calm = 1'b0;

    tick_if.valid <= 1'b0;
    for (int w = 0; w < 5000 && pending != 0; w++) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (pending != 0) $error("%0d result words never arrived", pending);

    $display("Checked %0d result words from %0d tick words over %0d register settings.",
             checked, words_sent, setups);
    $display("Saw %0d activations and %0d deactivations.", rise_cnt, fall_cnt);
    if (fail_cnt == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
